// ===== hdl/tdcref_pkg.sv =====
// Package: shared types and constants of the TDC edge time reference correction block.
package tdcref_pkg;

  localparam int CH_W     = 10;
  localparam int EPOCH_W  = 28;
  localparam int COARSE_W = 11;
  localparam int FINE_W   = 10;
  localparam int CAL_W    = 21;
  localparam int TIME_W   = 46;
  localparam int SPACE_W  = 8;

  // Epoch bits that survive the shift by the coarse width into 32 bits
  localparam int EPOCH_KEEP_W = 32 - COARSE_W;
  localparam int TICKS_W      = 32;
  localparam int PROD_W       = 45;

  localparam logic [12:0]       COARSE_PS    = 13'd5000;
  localparam logic [TIME_W-1:0] REF_WIDTH_PS = TIME_W'(10000);

  // Request type codes
  localparam logic [1:0] REQ_EDGE      = 2'd0;
  localparam logic [1:0] REQ_CAL_WRITE = 2'd1;
  localparam logic [1:0] REQ_EVT_START = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_DECIDE,
    ST_SUB,
    ST_EMIT_REL,
    ST_EMIT_NOREF,
    ST_EMIT_REF_RISE,
    ST_EMIT_REF_FALL
  } state_t;

  typedef enum logic [1:0] {
    OSEL_REF_RISE,
    OSEL_REF_FALL,
    OSEL_NOREF,
    OSEL_REL
  } out_sel_t;

  typedef struct packed {
    logic     accept;
    logic     clr;
    logic     store_ref;
    logic     out_load;
    out_sel_t out_sel;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_busy;
    logic is_ref;
    logic rising;
    logic tdc_ok;
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/tdcref_div.sv =====
// Iterative restoring divider: channel by spacing, one quotient bit a cycle.
module tdcref_div
  import tdcref_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [CH_W-1:0]    dividend,
  input  logic [SPACE_W-1:0] divisor,
  output logic               busy,
  output logic [CH_W-1:0]    quotient,
  output logic [SPACE_W-1:0] remainder
);

  localparam int CNT_W = $clog2(CH_W + 1);

  logic [CNT_W-1:0]   cnt_r;
  logic [CH_W-1:0]    dvd_r;
  logic [SPACE_W-1:0] rem_r;
  logic [SPACE_W-1:0] dsr_r;
  logic [SPACE_W:0]   trial;
  logic [SPACE_W:0]   diff;
  logic               ge;

  always_comb begin
    trial = {rem_r, dvd_r[CH_W-1]};
    diff  = trial - {1'b0, dsr_r};
    ge    = (trial >= {1'b0, dsr_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_W'(CH_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dsr_r <= (divisor == '0) ? SPACE_W'(1) : divisor;
    end else if (cnt_r != '0) begin
      rem_r <= ge ? diff[SPACE_W-1:0] : trial[SPACE_W-1:0];
      dvd_r <= {dvd_r[CH_W-2:0], ge};
    end
  end

  assign busy      = (cnt_r != '0);
  assign quotient  = dvd_r;
  assign remainder = rem_r;

endmodule

// ===== hdl/tdcref_dp.sv =====
// Datapath: timestamp arithmetic, reference and calibration stores, output register.
module tdcref_dp
  import tdcref_pkg::*;
#(
  parameter int TDC_COUNT     = 64,
  parameter int CHANNEL_COUNT = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic               cfg_wr_en,
  input  logic [SPACE_W-1:0] cfg_wr_data,
  input  logic [79:0]        in_tdata,
  input  logic [2:0]         in_tuser,
  input  logic               out_tready,
  output logic               out_tvalid,
  output logic [55:0]        out_tdata,
  output logic [1:0]         out_tuser,
  output logic               out_tlast
);

  localparam int TDC_AW = (TDC_COUNT > 1) ? $clog2(TDC_COUNT) : 1;
  localparam int CAL_AW = $clog2(CHANNEL_COUNT);

  // Input field slices
  logic [1:0]          in_req;
  logic [CH_W-1:0]     in_ch;
  logic                in_rise;
  logic [EPOCH_W-1:0]  in_epoch;
  logic [COARSE_W-1:0] in_coarse;
  logic [FINE_W-1:0]   in_fine;
  logic [CAL_W-1:0]    in_cal;

  assign in_req    = in_tuser[1:0];
  assign in_rise   = in_tuser[2];
  assign in_ch     = in_tdata[9:0];
  assign in_epoch  = in_tdata[37:10];
  assign in_coarse = in_tdata[48:38];
  assign in_fine   = in_tdata[58:49];
  assign in_cal    = in_tdata[79:59];

  logic [SPACE_W-1:0]  spacing_r;
  logic [CH_W-1:0]     ch_r;
  logic                rising_r;
  logic [FINE_W-1:0]   fine_r;
  logic [PROD_W-1:0]   prod_r;
  logic [TIME_W-1:0]   abs_hit_r;
  logic [TIME_W-1:0]   rel_r;
  logic [TIME_W-1:0]   ref_rd_r;
  logic [CAL_W-1:0]    cal_rd_r;
  logic [CAL_AW-1:0]   clr_addr_r;
  logic [TDC_COUNT-1:0] valid_r;

  logic [TIME_W-1:0] ref_mem [TDC_COUNT];
  logic [CAL_W-1:0]  cal_mem [CHANNEL_COUNT];

  logic [CH_W-1:0]    quotient;
  logic [SPACE_W-1:0] remainder;
  logic               div_busy;
  logic [TDC_AW-1:0]  tdc_idx;
  logic               tdc_in_range;
  logic               ch_in_range;
  logic               in_ch_in_range;
  logic               div_start;
  logic               cal_wr;
  logic [TICKS_W-1:0] in_ticks;
  logic [TIME_W-1:0]  cal_ext;
  logic [TIME_W-1:0]  time_sel;

  assign div_start      = cmd.accept && (in_req == REQ_EDGE);
  assign in_ch_in_range = ({22'd0, in_ch} < 32'(CHANNEL_COUNT));
  assign cal_wr         = cmd.accept && (in_req == REQ_CAL_WRITE) && in_ch_in_range;
  assign ch_in_range    = ({22'd0, ch_r} < 32'(CHANNEL_COUNT));
  assign tdc_idx        = quotient[TDC_AW-1:0];
  assign tdc_in_range   = ({22'd0, quotient} < 32'(TDC_COUNT));
  assign in_ticks       = {in_epoch[EPOCH_KEEP_W-1:0], in_coarse};

  tdcref_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (in_ch),
    .divisor   (spacing_r),
    .busy      (div_busy),
    .quotient  (quotient),
    .remainder (remainder)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spacing_r <= SPACE_W'(1);
    end else if (cfg_wr_en) begin
      spacing_r <= cfg_wr_data;
    end
  end

  // Capture the edge and start its absolute time
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ch_r     <= in_ch;
      rising_r <= in_rise;
      fine_r   <= in_fine;
      prod_r   <= PROD_W'(in_ticks) * PROD_W'(COARSE_PS);
    end
    abs_hit_r <= TIME_W'(prod_r) - TIME_W'(fine_r);
    rel_r     <= abs_hit_r - ref_rd_r;
  end

  // Reference store: valid bits in flops, times in a memory
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.accept && (in_req == REQ_EVT_START)) begin
      valid_r <= '0;
    end else if (cmd.store_ref && tdc_in_range) begin
      valid_r[tdc_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_ref && tdc_in_range) begin
      ref_mem[tdc_idx] <= abs_hit_r;
    end
    ref_rd_r <= ref_mem[tdc_idx];
  end

  // Calibration memory with clearing sweep after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      cal_mem[clr_addr_r] <= '0;
    end else if (cal_wr) begin
      cal_mem[CAL_AW'(in_ch)] <= in_cal;
    end
    cal_rd_r <= cal_mem[CAL_AW'(ch_r)];
  end

  always_comb begin
    cal_ext = '0;
    if (!rising_r && ch_in_range) begin
      cal_ext = {{(TIME_W - CAL_W){cal_rd_r[CAL_W-1]}}, cal_rd_r};
    end
    case (cmd.out_sel)
      OSEL_REF_RISE: time_sel = abs_hit_r;
      OSEL_REF_FALL: time_sel = abs_hit_r + REF_WIDTH_PS;
      OSEL_NOREF:    time_sel = '0;
      OSEL_REL:      time_sel = rel_r - cal_ext;
      default:       time_sel = '0;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_tdata <= {time_sel, ch_r};
      case (cmd.out_sel)
        OSEL_REF_RISE: begin
          out_tuser <= 2'b01;
          out_tlast <= 1'b0;
        end
        OSEL_REF_FALL: begin
          out_tuser <= 2'b00;
          out_tlast <= 1'b1;
        end
        OSEL_NOREF: begin
          out_tuser <= {1'b1, rising_r};
          out_tlast <= 1'b1;
        end
        default: begin
          out_tuser <= {1'b0, rising_r};
          out_tlast <= 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    sts.clr_last = (clr_addr_r == CAL_AW'(CHANNEL_COUNT - 1));
    sts.div_busy = div_busy;
    sts.is_ref   = (remainder == '0);
    sts.rising   = rising_r;
    sts.tdc_ok   = tdc_in_range && valid_r[tdc_idx];
    sts.out_free = !out_tvalid || out_tready;
  end

endmodule

// ===== hdl/tdcref_ctrl.sv =====
// Controller: sequences clearing, division, lookup and result emission.
module tdcref_ctrl
  import tdcref_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic [1:0] in_req,
  input  sts_t       sts,
  output cmd_t       cmd,
  output logic       in_tready
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_tready     = 1'b0;
    cmd.accept    = 1'b0;
    cmd.clr       = 1'b0;
    cmd.store_ref = 1'b0;
    cmd.out_load  = 1'b0;
    cmd.out_sel   = OSEL_REL;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          if (in_req == REQ_EDGE) begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (!sts.div_busy) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts.is_ref) begin
          // drop falling edges of reference channels
          if (sts.rising) begin
            cmd.store_ref = 1'b1;
            state_nxt     = ST_EMIT_REF_RISE;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else if (!sts.tdc_ok) begin
          state_nxt = ST_EMIT_NOREF;
        end else begin
          state_nxt = ST_SUB;
        end
      end
      ST_SUB: begin
        state_nxt = ST_EMIT_REL;
      end
      ST_EMIT_REL: begin
        cmd.out_sel = OSEL_REL;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_EMIT_NOREF: begin
        cmd.out_sel = OSEL_NOREF;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_EMIT_REF_RISE: begin
        cmd.out_sel = OSEL_REF_RISE;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_EMIT_REF_FALL;
        end
      end
      ST_EMIT_REF_FALL: begin
        cmd.out_sel = OSEL_REF_FALL;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/tdc_edge_time_reference_correct.sv =====
// Top level: TDC edge time reference correction block.
//
// Input stream (in_*): one transaction per request. tuser selects the request kind
// (edge hit, calibration write, event start) and carries the edge polarity; tdata
// carries channel, epoch, coarse, fine and calibration offset.
// Result stream (out_*): channel and time in ps on tdata, polarity and the missing
// reference flag on tuser; tlast marks the final result of an input transaction.
// A reference channel's rising edge gives two results (rising, then falling 10 ns
// later); a reference falling edge gives none; any other edge gives one.
// An edge holds the sequencer through the wait on the one-bit-per-cycle divider that
// splits channel by spacing, the decide state and, for a relative result, the subtract
// state, then while its results are emitted; an ignored reference falling edge ends at
// the decide state. Calibration writes and event starts finish in the accepting cycle,
// one every cycle.
// Results sit in an output register, so the next transaction is accepted while the
// last result still waits; a stalled receiver holds the sequencer only when a new
// result is due.
// Reset: spacing returns to 1, all references become invalid, and a clearing sweep
// of all CHANNEL_COUNT entries (1024 by default) zeroes the calibration table;
// in_tready stays low during the sweep, configuration writes are still taken.
module tdc_edge_time_reference_correct
  import tdcref_pkg::*;
#(
  parameter int TDC_COUNT     = 64,
  parameter int CHANNEL_COUNT = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration: ref_channel_spacing
  input  logic               cfg_wr_en,
  input  logic [SPACE_W-1:0] cfg_wr_data,
  // input stream
  input  logic               in_tvalid,
  output logic               in_tready,
  // tdata: channel[9:0], epoch[37:10], coarse[48:38], fine[58:49], cal_offset[79:59]
  input  logic [79:0]        in_tdata,
  // tuser: req_type[1:0], rising[2]
  input  logic [2:0]         in_tuser,
  // result stream
  output logic               out_tvalid,
  input  logic               out_tready,
  // tdata: out_channel[9:0], time_ps[55:10]
  output logic [55:0]        out_tdata,
  // tuser: out_rising[0], no_reference[1]
  output logic [1:0]         out_tuser,
  output logic               out_tlast
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: hold the datapath's commands per state
  tdcref_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_req    (in_tuser[1:0]),
    .sts       (sts),
    .cmd       (cmd),
    .in_tready (in_tready)
  );

  // arithmetic, stores and output register
  tdcref_dp #(
    .TDC_COUNT     (TDC_COUNT),
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

endmodule

// ===== hdl/tdcref_checker.sv =====
// Checker: port-level assertions for the TDC edge time reference correction block.
module tdcref_checker
  import tdcref_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [2:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // the clearing sweep keeps the input closed right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !in_tready)
    else $error("input ready during calibration clearing");

  // an edge transaction occupies the sequencer for the following cycle
  a_edge_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser[1:0] == REQ_EDGE) |=> !in_tready)
    else $error("edge accepted without busy period");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // a missing reference gives a single result
  a_noref_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast)
    else $error("missing-reference result not last");

  // only the reference rising edge is followed by another result
  a_first_is_ref_rise: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tuser[0] && !out_tuser[1])
    else $error("non-last result is not a reference rising edge");

endmodule

bind tdc_edge_time_reference_correct tdcref_checker u_tdcref_checker (.*);

// ===== verif/tb_tdc_edge_time_reference_correct.sv =====
// Self-checking testbench of the TDC edge time reference correction block.
`timescale 1ns / 100ps

module tb_tdc_edge_time_reference_correct;
  import tdcref_pkg::*;

  // Block geometry and timing constants, as the block is built by default
  localparam int TDC_COUNT     = 64;
  localparam int CHANNEL_COUNT = 1024;
  localparam longint COARSE_STEP_PS = 5000;
  localparam longint REF_PULSE_PS   = 10000;
  localparam logic [1:0] REQ_RESERVED = 2'd3;

  // Lets an edge transaction in flight finish before a register write
  localparam int SETTLE_CYCLES  = 30;
  // Covers the calibration clearing sweep after reset with a wide margin
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 50;

  typedef struct packed {
    logic [1:0]  req;
    logic [9:0]  ch;
    logic        rising;
    logic [27:0] epoch;
    logic [10:0] coarse;
    logic [9:0]  fine;
    logic [20:0] cal;
  } tdc_req_t;

  typedef struct packed {
    logic [9:0]  ch;
    logic        rising;
    logic [45:0] time_ps;
    logic        noref;
    logic        last;
  } edge_time_t;

  // Clock, reset and every block input start at known values
  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [7:0]  cfg_wr_data = '0;
  logic        in_tvalid   = 1'b0;
  logic [79:0] in_tdata    = '0;
  logic [2:0]  in_tuser    = '0;
  logic        out_tready  = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [55:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  // Predictor state: mirror of the spacing register, reference stores and calibration table
  logic [7:0]         spacing_reg = 8'd1;
  logic [27:0]        ref_epoch  [TDC_COUNT];
  logic [10:0]        ref_coarse [TDC_COUNT];
  logic [9:0]         ref_fine   [TDC_COUNT];
  bit                 ref_valid  [TDC_COUNT];
  logic signed [20:0] cal_table  [CHANNEL_COUNT] = '{default: '0};

  edge_time_t pending_times[$];

  int errors          = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int settings_used   = 1;
  int quiet_cycles    = 0;
  int ready_hold      = 0;
  bit idle_en         = 1'b1;

  always #6 clk = ~clk;

  tdc_edge_time_reference_correct dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // ---------------------------------------------------------------------------
  // Time prediction
  // ---------------------------------------------------------------------------

  // Register value zero behaves as a spacing of one
  function automatic int unsigned eff_spacing();
    return (spacing_reg == 8'd0) ? 1 : int'(spacing_reg);
  endfunction

  // Absolute edge time: epoch shifted by the coarse width and kept to 32 bits
  function automatic longint abs_time_ps(input logic [27:0] ep, input logic [10:0] co,
                                         input logic [9:0] fi);
    logic [31:0] ticks;
    ticks = {ep[20:0], 11'd0};
    return longint'({32'd0, ticks}) * COARSE_STEP_PS
         + longint'({53'd0, co}) * COARSE_STEP_PS
         - longint'({54'd0, fi});
  endfunction

  function automatic void push_time(input logic [9:0] ch, input logic rising,
                                    input longint t, input logic noref, input logic last);
    edge_time_t e;
    e.ch      = ch;
    e.rising  = rising;
    e.time_ps = t[45:0];
    e.noref   = noref;
    e.last    = last;
    pending_times.push_back(e);
  endfunction

  // Update the mirrored state for one accepted transaction and queue its results
  function automatic void predict_edge_times(input tdc_req_t r);
    int unsigned sp;
    int unsigned tdc;
    bit          is_ref;
    longint      t;
    sp     = eff_spacing();
    tdc    = int'(r.ch) / sp;
    is_ref = (int'(r.ch) % sp) == 0;
    case (r.req)
      REQ_CAL_WRITE: begin
        cal_table[r.ch] = r.cal;
      end
      REQ_EVT_START: begin
        foreach (ref_valid[i]) ref_valid[i] = 1'b0;
      end
      REQ_EDGE: begin
        if (is_ref) begin
          // Falling edge of a reference channel gives nothing
          if (r.rising) begin
            if (tdc < TDC_COUNT) begin
              ref_epoch[tdc]  = r.epoch;
              ref_coarse[tdc] = r.coarse;
              ref_fine[tdc]   = r.fine;
              ref_valid[tdc]  = 1'b1;
            end
            t = abs_time_ps(r.epoch, r.coarse, r.fine);
            push_time(r.ch, 1'b1, t, 1'b0, 1'b0);
            push_time(r.ch, 1'b0, t + REF_PULSE_PS, 1'b0, 1'b1);
          end
        end else if (tdc >= TDC_COUNT || !ref_valid[tdc]) begin
          push_time(r.ch, r.rising, 0, 1'b1, 1'b1);
        end else begin
          t = abs_time_ps(r.epoch, r.coarse, r.fine)
            - abs_time_ps(ref_epoch[tdc], ref_coarse[tdc], ref_fine[tdc]);
          if (!r.rising) t -= cal_table[r.ch];
          push_time(r.ch, r.rising, t, 1'b0, 1'b1);
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking and receiver back-pressure
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [45:0] exp_v,
                             input logic [45:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // Sample at the edge on pre-edge values, then draw the next stall
  always @(posedge clk) begin
    edge_time_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_times.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual ch=%0d time=%h",
                 $time, out_tdata[9:0], out_tdata[55:10]);
      end else begin
        want = pending_times.pop_front();
        check_field("out_channel",  46'(want.ch),     46'(out_tdata[9:0]));
        check_field("out_rising",   46'(want.rising), 46'(out_tuser[0]));
        check_field("time_ps",      want.time_ps,     out_tdata[55:10]);
        check_field("no_reference", 46'(want.noref),  46'(out_tuser[1]));
        check_field("tlast",        46'(want.last),   46'(out_tlast));
        results_checked++;
      end
      ready_hold = idle_en ? $urandom_range(0, 9) : 0;
    end
    if (ready_hold > 0) begin
      out_tready <= 1'b0;
      ready_hold--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog: end the run if neither channel moves a transaction for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding", $time,
               pending_times.size());
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic tdc_req_t mk_req(input logic [1:0] req, input logic [9:0] ch,
                                      input logic rising, input logic [27:0] ep,
                                      input logic [10:0] co, input logic [9:0] fi,
                                      input logic [20:0] cal);
    tdc_req_t r;
    r.req    = req;
    r.ch     = ch;
    r.rising = rising;
    r.epoch  = ep;
    r.coarse = co;
    r.fine   = fi;
    r.cal    = cal;
    return r;
  endfunction

  // Send one transaction; called at a rising edge, returns at its acceptance edge
  // with tvalid still high so that a back-to-back follow-up needs no toggle
  task automatic send_request(input tdc_req_t r);
    int gap;
    gap = idle_en ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {r.cal, r.fine, r.coarse, r.epoch, r.ch};
    in_tuser  <= {r.rising, r.req};
    do @(posedge clk); while (!in_tready);
    predict_edge_times(r);
    if (r.req != REQ_RESERVED) items_sent++;
  endtask

  // Drop tvalid, wait for every queued result, then let any silent work finish
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_times.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_spacing(input logic [7:0] value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    spacing_reg = value;
    settings_used++;
  endtask

  task automatic send_noise_request();
    send_request(mk_req(2'($urandom_range(0, 3)), 10'($urandom), 1'($urandom),
                        28'($urandom), 11'($urandom), 10'($urandom), 21'($urandom)));
  endtask

  // One event: clear, place references, then hits, calibration writes and reference edges
  task automatic run_event();
    int unsigned sp;
    int unsigned max_tdc;
    int unsigned tdc;
    int unsigned span;
    int unsigned off;
    int unsigned choice;
    int unsigned ref_tdcs[$];
    logic [27:0] base_epoch;
    logic [9:0]  ch;
    sp         = eff_spacing();
    max_tdc    = (1023 / sp < TDC_COUNT - 1) ? 1023 / sp : TDC_COUNT - 1;
    base_epoch = 28'($urandom);
    send_request(mk_req(REQ_EVT_START, 10'($urandom), 1'($urandom), 28'($urandom),
                        11'($urandom), 10'($urandom), 21'($urandom)));
    repeat ($urandom_range(1, 4)) begin
      tdc = $urandom_range(0, max_tdc);
      ref_tdcs.push_back(tdc);
      send_request(mk_req(REQ_EDGE, 10'(tdc * sp), 1'b1,
                          28'(base_epoch + $urandom_range(0, 3)),
                          11'($urandom), 10'($urandom), 21'($urandom)));
    end
    repeat ($urandom_range(2, 8)) begin
      choice = $urandom_range(0, 9);
      tdc    = ref_tdcs[$urandom_range(0, ref_tdcs.size() - 1)];
      // Occasionally aim at a TDC that may have no reference this event
      if (choice == 0) tdc = $urandom_range(0, max_tdc);
      span = 1023 - tdc * sp;
      if (span > sp - 1) span = sp - 1;
      off = (span == 0) ? 0 : $urandom_range(1, span);
      ch  = 10'(tdc * sp + off);
      if (choice == 1) begin
        send_request(mk_req(REQ_CAL_WRITE, ch, 1'($urandom), 28'($urandom),
                            11'($urandom), 10'($urandom), 21'($urandom)));
      end else if (choice == 2) begin
        // Reference again: a falling one is ignored, a rising one overwrites
        send_request(mk_req(REQ_EDGE, 10'(tdc * sp), 1'($urandom),
                            28'(base_epoch + $urandom_range(0, 3)), 11'($urandom),
                            10'($urandom), 21'($urandom)));
      end else begin
        send_request(mk_req(REQ_EDGE, ch, 1'($urandom),
                            28'(base_epoch + $urandom_range(0, 2)),
                            11'($urandom), 10'($urandom), 21'($urandom)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset state: spacing one, no references, calibration table zero
  task automatic test_after_reset();
    send_request(mk_req(REQ_EDGE, 10'd0, 1'b1, '0, '0, '0, '0));
    send_request(mk_req(REQ_EDGE, 10'd0, 1'b0, '0, '0, '0, '0));
    // Reference of a TDC beyond the store still gives both absolute times
    send_request(mk_req(REQ_EDGE, 10'd1000, 1'b1, 28'd77, 11'd5, 10'd9, '0));
    write_spacing(8'd8);
    send_request(mk_req(REQ_EDGE, 10'd9, 1'b0, 28'd3, 11'd3, 10'd3, '0));
    send_request(mk_req(REQ_EDGE, 10'd8, 1'b1, 28'd3, 11'd100, 10'd20, '0));
    send_request(mk_req(REQ_EDGE, 10'd9, 1'b0, 28'd3, 11'd200, 10'd1, '0));
  endtask

  // Field extremes, calibration limits, reference loss and overwrite, spacing zero
  task automatic test_directed_cases();
    send_request(mk_req(REQ_EDGE, 10'd16, 1'b1, 28'hFFFFFFF, 11'h7FF, 10'd0, '0));
    send_request(mk_req(REQ_EDGE, 10'd17, 1'b1, 28'd0, 11'd0, 10'h3FF, '0));
    send_request(mk_req(REQ_CAL_WRITE, 10'd17, 1'b0, '0, '0, '0, 21'h0FFFFF));
    send_request(mk_req(REQ_EDGE, 10'd17, 1'b0, 28'hFFFFFFF, 11'h7FF, 10'h3FF, '0));
    send_request(mk_req(REQ_CAL_WRITE, 10'd18, 1'b0, '0, '0, '0, 21'h100000));
    send_request(mk_req(REQ_EDGE, 10'd18, 1'b0, 28'd0, 11'd1, 10'd0, '0));
    send_request(mk_req(REQ_CAL_WRITE, 10'd1023, 1'b1, '1, '1, '1, 21'($urandom)));
    send_request(mk_req(REQ_EDGE, 10'd1016, 1'b1, 28'($urandom), 11'($urandom),
                        10'($urandom), '0));
    send_request(mk_req(REQ_EDGE, 10'd1023, 1'b0, 28'd5, 11'd5, 10'd5, '0));
    send_request(mk_req(REQ_EDGE, 10'd16, 1'b1, 28'd1, 11'd2, 10'd3, '0));
    send_request(mk_req(REQ_EDGE, 10'd19, 1'b1, 28'd1, 11'd2, 10'd3, '0));
    send_request(mk_req(REQ_RESERVED, '1, 1'b1, '1, '1, '1, '1));
    send_request(mk_req(REQ_EVT_START, '1, 1'b1, '1, '1, '1, '1));
    send_request(mk_req(REQ_EDGE, 10'd17, 1'b1, 28'd1, 11'd2, 10'd3, '0));
    send_request(mk_req(REQ_EDGE, 10'd16, 1'b0, 28'd1, 11'd2, 10'd3, '0));
    write_spacing(8'd0);
    send_request(mk_req(REQ_EDGE, 10'd63, 1'b1, 28'd9, 11'd9, 10'd9, '0));
    send_request(mk_req(REQ_EDGE, 10'd64, 1'b1, 28'd9, 11'd9, 10'd9, '0));
  endtask

  // Random events and noise across several spacing settings, extremes included
  task automatic test_spacing_sweep();
    logic [7:0] settings [7] = '{8'd0, 8'd255, 8'd128, 8'd3, 8'd16, 8'd1, 8'd2};
    int  phase_end;
    bit  paused;
    paused      = 1'b0;
    settings[6] = 8'($urandom_range(2, 127));
    foreach (settings[i]) begin
      write_spacing(settings[i]);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        // Hold off once mid-phase until the output side has caught up
        if (i == 3 && !paused && items_sent >= phase_end - PHASE_ITEMS / 2) begin
          drain_results();
          paused = 1'b1;
        end
        if ($urandom_range(0, 4) == 0) send_noise_request();
        else run_event();
      end
    end
  endtask

  // No gaps on either side: transactions and results back to back
  task automatic test_back_to_back();
    int phase_end;
    idle_en = 1'b0;
    write_spacing(8'd4);
    phase_end = items_sent + PHASE_ITEMS;
    while (items_sent < phase_end) begin
      if ($urandom_range(0, 5) == 0) send_noise_request();
      else run_event();
    end
    drain_results();
    idle_en = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_after_reset();
    test_directed_cases();
    test_spacing_sweep();
    test_back_to_back();
    drain_results();
    $display("Covered %0d requests and %0d checked times over %0d spacing settings",
             items_sent, results_checked, settings_used);
    $display("Reference, relative, calibrated and missing-reference paths; %0d errors",
             errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
